// ===== rtl/sshc_pkg.sv =====
// Shared types, constants and codes for the strip seed hit clusterer.
// No dependencies; the other design files but sshc_ram, and the bench, import this package.
package sshc_pkg;

    // Sizing
    localparam int MAX_CLUSTER = 32;
    localparam int CHANNELS    = 256;
    localparam int ADC_BITS    = 16;
    localparam int IDX_W       = (MAX_CLUSTER > 1) ? $clog2(MAX_CLUSTER) : 1;
    localparam int CNT_W       = $clog2(MAX_CLUSTER + 1);

    // Field widths
    localparam int CH_W    = 8;
    localparam int ADC_W   = 16;
    localparam int MEAN_W  = 20;
    localparam int WIDTH_W = 16;
    localparam int CLNUM_W = 7;
    localparam int FACT_W  = 8;
    localparam int HIT_W   = CH_W + ADC_W + MEAN_W + WIDTH_W;

    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((32'd1 << ADC_BITS) - 1);

    // Configuration port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    typedef enum logic [2:0] {
        REG_HIT_FACTOR  = 3'd0,
        REG_SEED_FACTOR = 3'd1,
        REG_MASK_0      = 3'd2,
        REG_MASK_1      = 3'd3,
        REG_MASK_2      = 3'd4,
        REG_MASK_3      = 3'd5
    } reg_idx_t;

    localparam logic [FACT_W-1:0] HIT_FACTOR_RST  = 8'd48;
    localparam logic [FACT_W-1:0] SEED_FACTOR_RST = 8'd80;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [FACT_W-1:0]  hit_factor;
        logic [FACT_W-1:0]  seed_factor;
        logic [3:0][63:0]   mask;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT_GAP,
        ST_APPEND,
        ST_CLOSE_EOE,
        ST_EMIT_EOE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic append;
        logic emit;
        logic clear_cluster;
        logic count_inc;
        logic count_zero;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic close_first;
        logic has_seed;
        logic len_nonzero;
        logic eoe;
        logic emit_done;
    } status_t;

endpackage

// ===== rtl/sshc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sshc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic                               re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                   rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/sshc_regs.sv =====
// APB-style configuration registers: thresholds and channel mask words.
// Depends on sshc_pkg.
module sshc_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sshc_pkg::PADDR_W-1:0]   paddr,
    input  logic [sshc_pkg::PDATA_W-1:0]   pwdata,
    output logic [sshc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output sshc_pkg::cfg_t                 cfg
);
    import sshc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_HIT_FACTOR:  cfg_next.hit_factor  = pwdata[FACT_W-1:0];
                REG_SEED_FACTOR: cfg_next.seed_factor = pwdata[FACT_W-1:0];
                REG_MASK_0:      cfg_next.mask[0]     = pwdata;
                REG_MASK_1:      cfg_next.mask[1]     = pwdata;
                REG_MASK_2:      cfg_next.mask[2]     = pwdata;
                REG_MASK_3:      cfg_next.mask[3]     = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hit_factor  <= HIT_FACTOR_RST;
            cfg_reg.seed_factor <= SEED_FACTOR_RST;
            cfg_reg.mask        <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_HIT_FACTOR:  prdata = {{(PDATA_W-FACT_W){1'b0}}, cfg_reg.hit_factor};
            REG_SEED_FACTOR: prdata = {{(PDATA_W-FACT_W){1'b0}}, cfg_reg.seed_factor};
            REG_MASK_0:      prdata = cfg_reg.mask[0];
            REG_MASK_1:      prdata = cfg_reg.mask[1];
            REG_MASK_2:      prdata = cfg_reg.mask[2];
            REG_MASK_3:      prdata = cfg_reg.mask[3];
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule

// ===== rtl/sshc_datapath.sv =====
// Datapath: sample register, threshold compares, cluster state, hit buffer
// and the emit pipeline with its output register. Depends on sshc_pkg, sshc_ram.
module sshc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sshc_pkg::cfg_t                  cfg,
    input  logic                            capture,
    input  logic [sshc_pkg::CH_W-1:0]       s_channel,
    input  logic [sshc_pkg::ADC_W-1:0]      s_adc_value,
    input  logic [sshc_pkg::MEAN_W-1:0]     s_pedestal_mean,
    input  logic [sshc_pkg::WIDTH_W-1:0]    s_pedestal_width,
    input  logic                            s_end_of_event,
    input  sshc_pkg::cmd_t                  cmd,
    output sshc_pkg::status_t               status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sshc_pkg::CLNUM_W-1:0]    m_cluster_number,
    output logic [sshc_pkg::CH_W-1:0]       m_hit_channel,
    output logic [sshc_pkg::ADC_W-1:0]      m_hit_adc,
    output logic [sshc_pkg::MEAN_W-1:0]     m_hit_pedestal_mean,
    output logic [sshc_pkg::WIDTH_W-1:0]    m_hit_pedestal_width,
    output logic                            m_bad_channel_cluster,
    output logic                            m_golden_gate_cluster,
    output logic                            m_last_of_cluster
);
    import sshc_pkg::*;

    // Sample register
    logic [CH_W-1:0]    ch_reg;
    logic [ADC_W-1:0]   adc_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic               eoe_reg;

    // Cluster state
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               phv_reg, phv_next;
    logic [CH_W-1:0]    phc_reg, phc_next;
    logic               seed_reg, seed_next;
    logic               masked_reg, masked_next;
    logic               split_reg, split_next;
    logic               psv_reg, psv_next;
    logic [CH_W-1:0]    psc_reg, psc_next;
    logic [CLNUM_W-1:0] clnum_reg, clnum_next;

    // Emit pipeline
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               rv_reg, rv_next;
    logic [IDX_W-1:0]   ridx_reg;
    logic               ov_reg, ov_next;
    logic               issue, load;
    logic [HIT_W-1:0]   rdata;

    // Output register
    logic [CLNUM_W-1:0] o_clnum_reg;
    logic [HIT_W-1:0]   o_hit_reg;
    logic               o_bad_reg, o_gold_reg, o_last_reg;

    // Compares
    logic signed [25:0] lhs;
    logic [23:0]        rhs_hit, rhs_seed;
    logic               is_hit, is_seed, is_masked, contig, seed_contig;
    logic               ram_we;

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (capture) begin
            ch_reg    <= s_channel;
            adc_reg   <= s_adc_value & ADC_MASK;
            mean_reg  <= s_pedestal_mean;
            width_reg <= s_pedestal_width;
            eoe_reg   <= s_end_of_event;
        end
    end

    // Pedestal-subtracted value against factor * width, both in Q.8
    assign lhs      = $signed({2'b00, adc_reg, 8'h00}) - $signed({2'b00, mean_reg, 4'h0});
    assign rhs_hit  = 24'(cfg.hit_factor) * 24'(width_reg);
    assign rhs_seed = 24'(cfg.seed_factor) * 24'(width_reg);
    assign is_hit   = lhs > $signed({2'b00, rhs_hit});
    assign is_seed  = lhs > $signed({2'b00, rhs_seed});

    // Channels beyond the plane count as masked
    assign is_masked = ({1'b0, ch_reg} >= 9'(CHANNELS)) || cfg.mask[ch_reg[7:6]][ch_reg[5:0]];

    assign contig      = phv_reg && ({1'b0, ch_reg} == {1'b0, phc_reg} + 9'd1);
    assign seed_contig = {1'b0, ch_reg} == {1'b0, psc_reg} + 9'd1;

    // Status to controller
    assign status.hit         = is_hit;
    assign status.close_first = (len_reg != '0) &&
                                (!contig || (len_reg >= CNT_W'(MAX_CLUSTER)));
    assign status.has_seed    = seed_reg;
    assign status.len_nonzero = len_reg != '0;
    assign status.eoe         = eoe_reg;
    assign status.emit_done   = (k_reg == len_reg) && !rv_reg;

    // Cluster state update
    always_comb begin
        len_next    = len_reg;
        phv_next    = phv_reg;
        phc_next    = phc_reg;
        seed_next   = seed_reg;
        masked_next = masked_reg;
        split_next  = split_reg;
        psv_next    = psv_reg;
        psc_next    = psc_reg;
        clnum_next  = clnum_reg;
        if (cmd.clear_cluster) begin
            len_next    = '0;
            phv_next    = 1'b0;
            phc_next    = '0;
            seed_next   = 1'b0;
            masked_next = 1'b0;
            split_next  = 1'b0;
            psv_next    = 1'b0;
            psc_next    = '0;
        end
        if (cmd.count_inc) begin
            clnum_next = clnum_reg + CLNUM_W'(1);
        end
        if (cmd.count_zero) begin
            clnum_next = '0;
        end
        if (cmd.append) begin
            if (len_reg < CNT_W'(MAX_CLUSTER)) begin
                len_next = len_reg + CNT_W'(1);
            end
            phv_next = 1'b1;
            phc_next = ch_reg;
            if (is_seed) begin
                seed_next = 1'b1;
                if (psv_reg && !seed_contig) begin
                    split_next = 1'b1;
                end else begin
                    psv_next = 1'b1;
                    psc_next = ch_reg;
                end
            end
            if (is_masked) begin
                masked_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            phv_reg    <= 1'b0;
            phc_reg    <= '0;
            seed_reg   <= 1'b0;
            masked_reg <= 1'b0;
            split_reg  <= 1'b0;
            psv_reg    <= 1'b0;
            psc_reg    <= '0;
            clnum_reg  <= '0;
        end else begin
            len_reg    <= len_next;
            phv_reg    <= phv_next;
            phc_reg    <= phc_next;
            seed_reg   <= seed_next;
            masked_reg <= masked_next;
            split_reg  <= split_next;
            psv_reg    <= psv_next;
            psc_reg    <= psc_next;
            clnum_reg  <= clnum_next;
        end
    end

    // Hit buffer
    assign ram_we = cmd.append && (len_reg < CNT_W'(MAX_CLUSTER));

    sshc_ram #(
        .WIDTH (HIT_W),
        .DEPTH (MAX_CLUSTER)
    ) u_hit_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[IDX_W-1:0]),
        .wdata ({ch_reg, adc_reg, mean_reg, width_reg}),
        .re    (issue),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    // Emit pipeline: read stage feeding the output register, one hit a cycle unless m_ready stalls
    assign load  = rv_reg && (!ov_reg || m_ready);
    assign issue = cmd.emit && (k_reg < len_reg) && (!rv_reg || load);

    always_comb begin
        k_next = k_reg;
        if (cmd.clear_cluster) begin
            k_next = '0;
        end else if (issue) begin
            k_next = k_reg + CNT_W'(1);
        end
        rv_next = issue ? 1'b1 : (load ? 1'b0 : rv_reg);
        ov_next = load ? 1'b1 : (m_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg  <= '0;
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            k_reg  <= k_next;
            rv_reg <= rv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            ridx_reg <= k_reg[IDX_W-1:0];
        end
        if (load) begin
            o_clnum_reg <= clnum_reg;
            o_hit_reg   <= rdata;
            o_bad_reg   <= masked_reg;
            o_gold_reg  <= split_reg;
            o_last_reg  <= ({1'b0, ridx_reg} + (IDX_W+1)'(1)) == (IDX_W+1)'(len_reg);
        end
    end

    // Result channel
    assign m_valid               = ov_reg;
    assign m_cluster_number      = o_clnum_reg;
    assign m_hit_channel         = o_hit_reg[HIT_W-1 -: CH_W];
    assign m_hit_adc             = o_hit_reg[MEAN_W+WIDTH_W +: ADC_W];
    assign m_hit_pedestal_mean   = o_hit_reg[WIDTH_W +: MEAN_W];
    assign m_hit_pedestal_width  = o_hit_reg[WIDTH_W-1:0];
    assign m_bad_channel_cluster = o_bad_reg;
    assign m_golden_gate_cluster = o_gold_reg;
    assign m_last_of_cluster     = o_last_reg;
endmodule

// ===== rtl/sshc_ctrl.sv =====
// Controller: sequences evaluation, cluster close, append and end of event.
// Depends on sshc_pkg.
module sshc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sshc_pkg::status_t   status,
    output sshc_pkg::cmd_t      cmd
);
    import sshc_pkg::*;

    state_t state_reg, state_next;
    logic   emit_seeded;

    assign emit_seeded = status.len_nonzero && status.has_seed;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.hit) begin
                    if (status.close_first && status.has_seed) state_next = ST_EMIT_GAP;
                    else                                       state_next = ST_APPEND;
                end else if (status.eoe) begin
                    state_next = ST_CLOSE_EOE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_GAP: begin
                if (status.emit_done) state_next = ST_APPEND;
            end
            ST_APPEND: begin
                state_next = status.eoe ? ST_CLOSE_EOE : ST_IDLE;
            end
            ST_CLOSE_EOE: begin
                state_next = emit_seeded ? ST_EMIT_EOE : ST_IDLE;
            end
            ST_EMIT_EOE: begin
                if (status.emit_done) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_EVAL: begin
                // unseeded cluster closed by a gap or a full buffer is dropped
                cmd.clear_cluster = status.hit && status.close_first && !status.has_seed;
            end
            ST_EMIT_GAP: begin
                cmd.emit          = 1'b1;
                cmd.clear_cluster = status.emit_done;
                cmd.count_inc     = status.emit_done;
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
            end
            ST_CLOSE_EOE: begin
                cmd.clear_cluster = !emit_seeded;
                cmd.count_zero    = !emit_seeded;
            end
            ST_EMIT_EOE: begin
                cmd.emit          = 1'b1;
                cmd.clear_cluster = status.emit_done;
                cmd.count_zero    = status.emit_done;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/strip_seed_hit_clusterer.sv =====
// Strip seed hit clusterer: one channel sample per item, seeded clusters out hit by hit.
// Each sample is evaluated, and appended if it is a hit, before the next one is taken;
// end of event adds a close step. Closing a seeded cluster holds the input while its hits
// are read out through the single read port of the hit buffer; m_ready stalls hold it longer.
// The hits of a closed cluster pass the hit buffer read stage and then the output register.
// Reset: synchronous active-low aresetn clears control and cluster state, loads
// hit_factor 48, seed_factor 80, masks 0. The hit buffer is not cleared.
module strip_seed_hit_clusterer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sshc_pkg::PADDR_W-1:0]    paddr,
    input  logic [sshc_pkg::PDATA_W-1:0]    pwdata,
    output logic [sshc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // sample items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sshc_pkg::CH_W-1:0]       s_channel,
    input  logic [sshc_pkg::ADC_W-1:0]      s_adc_value,
    input  logic [sshc_pkg::MEAN_W-1:0]     s_pedestal_mean,
    input  logic [sshc_pkg::WIDTH_W-1:0]    s_pedestal_width,
    input  logic                            s_end_of_event,
    // hit items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sshc_pkg::CLNUM_W-1:0]    m_cluster_number,
    output logic [sshc_pkg::CH_W-1:0]       m_hit_channel,
    output logic [sshc_pkg::ADC_W-1:0]      m_hit_adc,
    output logic [sshc_pkg::MEAN_W-1:0]     m_hit_pedestal_mean,
    output logic [sshc_pkg::WIDTH_W-1:0]    m_hit_pedestal_width,
    output logic                            m_bad_channel_cluster,
    output logic                            m_golden_gate_cluster,
    output logic                            m_last_of_cluster
);
    import sshc_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;
    logic    capture;

    assign capture = s_valid && s_ready;

    sshc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sshc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sshc_datapath u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg),
        .capture               (capture),
        .s_channel             (s_channel),
        .s_adc_value           (s_adc_value),
        .s_pedestal_mean       (s_pedestal_mean),
        .s_pedestal_width      (s_pedestal_width),
        .s_end_of_event        (s_end_of_event),
        .cmd                   (cmd),
        .status                (status),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_cluster_number      (m_cluster_number),
        .m_hit_channel         (m_hit_channel),
        .m_hit_adc             (m_hit_adc),
        .m_hit_pedestal_mean   (m_hit_pedestal_mean),
        .m_hit_pedestal_width  (m_hit_pedestal_width),
        .m_bad_channel_cluster (m_bad_channel_cluster),
        .m_golden_gate_cluster (m_golden_gate_cluster),
        .m_last_of_cluster     (m_last_of_cluster)
    );

    // No new item is taken while a cluster is being read out
    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.emit)
        else $error("item accepted during cluster readout");

    // An accepted item always moves the controller on to evaluation, where it is not ready
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("controller ready right after accept");

    // Counting a cluster always goes with closing it
    a_count_with_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.count_inc || cmd.count_zero) |-> cmd.clear_cluster)
        else $error("cluster count changed without a close");

    // Appending never overlaps a readout: the read pointer is back at the start
    a_append_not_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> (!cmd.emit && (u_dp.k_reg == '0)))
        else $error("append while readout in flight");
endmodule

// ===== bench/tb_strip_seed_hit_clusterer.sv =====
`timescale 1ns / 100ps
// Self-checking bench for strip_seed_hit_clusterer: random and directed channel samples,
// APB register writes, an in-order predictor of emitted cluster hits and a watchdog.
// Depends on sshc_pkg and the strip_seed_hit_clusterer RTL.

import sshc_pkg::*;

typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [ADC_W-1:0]   adc;
    logic [MEAN_W-1:0]  mean;
    logic [WIDTH_W-1:0] width;
    logic               eoe;
} sample_t;

typedef struct packed {
    logic [CLNUM_W-1:0] cluster_number;
    logic [CH_W-1:0]    channel;
    logic [ADC_W-1:0]   adc;
    logic [MEAN_W-1:0]  mean;
    logic [WIDTH_W-1:0] width;
    logic               bad_channel;
    logic               golden_gate;
    logic               last;
} cluster_hit_t;

// How a generated sample sits against the current thresholds
typedef enum int {LVL_NOISE, LVL_HIT, LVL_SEED, LVL_WILD} sample_level_t;

// Tracks the open cluster, predicts the hit items it releases and checks them in order
class cluster_tracker;
    logic [FACT_W-1:0]  hit_factor;
    logic [FACT_W-1:0]  seed_factor;
    logic [3:0][63:0]   mask;

    sample_t            buffered[MAX_CLUSTER];
    int                 length;
    bit                 prev_hit_ok;
    int                 prev_hit_ch;
    bit                 has_seed;
    bit                 has_masked;
    bit                 seeds_split;
    bit                 prev_seed_ok;
    int                 prev_seed_ch;
    logic [CLNUM_W-1:0] cluster_count;

    cluster_hit_t       pending_hits[$];

    int samples, hits_out, clusters_out, dropped, full_splits;
    int golden, bad, wraps, reg_writes, errors;

    function new();
        hit_factor    = HIT_FACTOR_RST;
        seed_factor   = SEED_FACTOR_RST;
        mask          = '0;
        cluster_count = '0;
        clear_cluster();
    endfunction

    function void clear_cluster();
        length       = 0;
        prev_hit_ok  = 1'b0;
        prev_hit_ch  = 0;
        has_seed     = 1'b0;
        has_masked   = 1'b0;
        seeds_split  = 1'b0;
        prev_seed_ok = 1'b0;
        prev_seed_ch = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] value);
        reg_writes++;
        case (idx)
            REG_HIT_FACTOR:  hit_factor  = value[FACT_W-1:0];
            REG_SEED_FACTOR: seed_factor = value[FACT_W-1:0];
            REG_MASK_0:      mask[0] = value;
            REG_MASK_1:      mask[1] = value;
            REG_MASK_2:      mask[2] = value;
            REG_MASK_3:      mask[3] = value;
            default: ;
        endcase
    endfunction

    // Exact Q.8 compare: adc*256 - mean*16 > factor*width
    function bit above(sample_t s, logic [FACT_W-1:0] factor);
        longint lhs;
        longint rhs;
        lhs = longint'(s.adc) * 256 - longint'(s.mean) * 16;
        rhs = longint'(factor) * longint'(s.width);
        return lhs > rhs;
    endfunction

    function bit masked(logic [CH_W-1:0] ch);
        if (int'(ch) >= CHANNELS)
            return 1'b1;
        return mask[ch[7:6]][ch[5:0]];
    endfunction

    // Release the open cluster if it holds a seed, then start over
    function void close_cluster();
        cluster_hit_t h;
        if (length > 0 && has_seed) begin
            for (int k = 0; k < length; k++) begin
                h.cluster_number = cluster_count;
                h.channel        = buffered[k].channel;
                h.adc            = buffered[k].adc;
                h.mean           = buffered[k].mean;
                h.width          = buffered[k].width;
                h.bad_channel    = has_masked;
                h.golden_gate    = seeds_split;
                h.last           = (k == length - 1);
                pending_hits     = {pending_hits, h};
            end
            clusters_out++;
            if (has_masked)
                bad++;
            if (seeds_split)
                golden++;
            if (cluster_count == '1)
                wraps++;
            cluster_count = cluster_count + 1'b1;
        end else if (length > 0) begin
            dropped++;
        end
        clear_cluster();
    endfunction

    function void take_sample(sample_t s);
        sample_t a;
        bit contiguous;
        samples++;
        a = s;
        a.adc = s.adc & ADC_MASK;
        if (above(a, hit_factor)) begin
            contiguous = prev_hit_ok && (int'(a.channel) == prev_hit_ch + 1);
            if (length > 0 && (!contiguous || length >= MAX_CLUSTER)) begin
                if (contiguous)
                    full_splits++;
                close_cluster();
            end
            if (length < MAX_CLUSTER) begin
                buffered[length] = a;
                length++;
            end
            prev_hit_ok = 1'b1;
            prev_hit_ch = a.channel;
            if (above(a, seed_factor)) begin
                has_seed = 1'b1;
                // a seed not next to the last one marks the golden gate
                if (prev_seed_ok && int'(a.channel) != prev_seed_ch + 1) begin
                    seeds_split = 1'b1;
                end else begin
                    prev_seed_ok = 1'b1;
                    prev_seed_ch = a.channel;
                end
            end
            if (masked(a.channel))
                has_masked = 1'b1;
        end
        if (a.eoe) begin
            close_cluster();
            cluster_count = '0;
        end
    endfunction

    function string show(cluster_hit_t h);
        return $sformatf("cluster %0d ch %0d adc %h mean %h width %h bad %b gg %b last %b",
                         h.cluster_number, h.channel, h.adc, h.mean, h.width,
                         h.bad_channel, h.golden_gate, h.last);
    endfunction

    function void note_error(string what);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $time, what);
    endfunction

    function void check_hit(cluster_hit_t got);
        cluster_hit_t want;
        if (pending_hits.size() == 0) begin
            note_error({"hit item with none expected: ", show(got)});
            return;
        end
        want = pending_hits.pop_front();
        hits_out++;
        if (got.cluster_number !== want.cluster_number || got.channel !== want.channel ||
            got.adc !== want.adc || got.mean !== want.mean || got.width !== want.width ||
            got.bad_channel !== want.bad_channel || got.golden_gate !== want.golden_gate ||
            got.last !== want.last)
            note_error({"hit item mismatch\n    expected ", show(want),
                        "\n    actual   ", show(got)});
    endfunction
endclass

module tb_strip_seed_hit_clusterer;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT      = 37;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [CH_W-1:0]     s_channel        = '0;
    logic [ADC_W-1:0]    s_adc_value      = '0;
    logic [MEAN_W-1:0]   s_pedestal_mean  = '0;
    logic [WIDTH_W-1:0]  s_pedestal_width = '0;
    logic                s_end_of_event   = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CLNUM_W-1:0]  m_cluster_number;
    logic [CH_W-1:0]     m_hit_channel;
    logic [ADC_W-1:0]    m_hit_adc;
    logic [MEAN_W-1:0]   m_hit_pedestal_mean;
    logic [WIDTH_W-1:0]  m_hit_pedestal_width;
    logic                m_bad_channel_cluster;
    logic                m_golden_gate_cluster;
    logic                m_last_of_cluster;

    cluster_tracker tracker;
    bit steady       = 1'b0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    strip_seed_hit_clusterer i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_channel            (s_channel),
        .s_adc_value          (s_adc_value),
        .s_pedestal_mean      (s_pedestal_mean),
        .s_pedestal_width     (s_pedestal_width),
        .s_end_of_event       (s_end_of_event),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_cluster_number     (m_cluster_number),
        .m_hit_channel        (m_hit_channel),
        .m_hit_adc            (m_hit_adc),
        .m_hit_pedestal_mean  (m_hit_pedestal_mean),
        .m_hit_pedestal_width (m_hit_pedestal_width),
        .m_bad_channel_cluster(m_bad_channel_cluster),
        .m_golden_gate_cluster(m_golden_gate_cluster),
        .m_last_of_cluster    (m_last_of_cluster)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: random back-pressure, one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check every accepted hit item
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_hit({m_cluster_number, m_hit_channel, m_hit_adc,
                               m_hit_pedestal_mean, m_hit_pedestal_width,
                               m_bad_channel_cluster, m_golden_gate_cluster,
                               m_last_of_cluster});
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d idle cycles, %0d hit items outstanding",
                     quiet_cycles, tracker.pending_hits.size());
            $display("strip_seed_hit_clusterer verification failed");
            $finish;
        end
    end

    task automatic send_sample(sample_t smp);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid          <= 1'b1;
        s_channel        <= smp.channel;
        s_adc_value      <= smp.adc;
        s_pedestal_mean  <= smp.mean;
        s_pedestal_width <= smp.width;
        s_end_of_event   <= smp.eoe;
        do @(posedge aclk); while (!s_ready);
        tracker.take_sample(smp);
    endtask

    // Stop offering, let every expected hit item drain, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending_hits.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup, access, then an idle phase with psel low
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sample_t pack_sample(int ch, int adc, int mean, int width, bit eoe);
        sample_t s;
        s.channel = CH_W'(ch);
        s.adc     = ADC_W'(adc);
        s.mean    = MEAN_W'(mean);
        s.width   = WIDTH_W'(width);
        s.eoe     = eoe;
        return s;
    endfunction

    // Sample placed below, between or above the current thresholds, or wholly random
    function automatic sample_t make_sample(int ch, sample_level_t lvl, bit eoe);
        int ped;
        int w;
        int lo;
        int hi;
        int delta;
        int adc;
        if (lvl == LVL_WILD)
            return pack_sample(ch & 255, int'($urandom_range(65535)),
                               int'($urandom_range(20'hFFFFF)),
                               int'($urandom_range(65535)), eoe);
        ped = ($urandom_range(99) < 20) ? int'($urandom_range(40000, 65000))
                                        : int'($urandom_range(0, 4000));
        w   = int'($urandom_range(1, 800));
        lo  = (int'(tracker.hit_factor) * w) / 256 + 1;
        hi  = (int'(tracker.seed_factor) * w) / 256 + 1;
        case (lvl)
            LVL_NOISE: delta = int'($urandom_range(0, lo + 19)) - 20;
            LVL_HIT:   delta = (hi > lo + 1) ? int'($urandom_range(lo + 1, hi - 1)) : lo + 1;
            default:   delta = ((hi > lo) ? hi : lo) + 1 + int'($urandom_range(0, 1500));
        endcase
        adc = ped + delta;
        if (adc < 0)
            adc = 0;
        if (adc > 65535)
            adc = 65535;
        return pack_sample(ch & 255, adc, ped * 16 + int'($urandom_range(0, 15)), w, eoe);
    endfunction

    // Run of channels, mostly consecutive, with hits and seeds at the given odds
    task automatic run_event(int first_ch, int n, int hit_pct, int seed_pct, bit close);
        int ch;
        int roll;
        sample_level_t lvl;
        ch = first_ch;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < seed_pct)
                lvl = LVL_SEED;
            else if (roll < hit_pct)
                lvl = LVL_HIT;
            else if (roll < 97)
                lvl = LVL_NOISE;
            else
                lvl = LVL_WILD;
            send_sample(make_sample(ch, lvl, close && (i == n - 1)));
            ch = (ch + (($urandom_range(99) < 6) ? 2 : 1)) & 255;
        end
    endtask

    // Mostly well-formed events, some full-length bursts, some loose noise
    task automatic run_phase(int budget);
        int stop_at;
        int kind;
        stop_at = tracker.samples + budget;
        while (tracker.samples < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 70)
                run_event($urandom_range(255), $urandom_range(3, 20), $urandom_range(30, 90),
                          $urandom_range(5, 40), $urandom_range(99) < 85);
            else if (kind < 80)
                run_event($urandom_range(200), $urandom_range(33, 45), 100, 12, 1'b1);
            else
                repeat ($urandom_range(1, 4))
                    send_sample(make_sample($urandom_range(255), LVL_WILD,
                                            $urandom_range(1) == 1));
        end
        drain();
    endtask

    initial begin : stimulus
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset thresholds (hit 3.0, seed 5.0); width 256, mean 0 gives
        // hit above adc 48 and seed above adc 80
        send_sample(pack_sample(0, 65535, 0, 0, 0));              // seed, max adc, no noise
        send_sample(pack_sample(1, 60, 0, 256, 0));
        send_sample(pack_sample(2, 10, 0, 256, 0));               // noise keeps cluster open
        send_sample(pack_sample(2, 60, 0, 256, 0));
        send_sample(pack_sample(3, 100, 0, 256, 0));              // seeds apart: golden gate
        send_sample(pack_sample(5, 60, 0, 256, 0));               // gap closes the cluster
        send_sample(pack_sample(6, 60, 0, 256, 1));               // unseeded, dropped
        send_sample(pack_sample(255, 100, 0, 256, 0));
        send_sample(pack_sample(0, 100, 0, 256, 0));              // no wrap from 255 to 0
        send_sample(pack_sample(1, 100, 0, 256, 1));
        send_sample(pack_sample(128, 0, 20'hFFFFF, 16'hFFFF, 0));
        send_sample(pack_sample(127, 65535, 20'hFFFFF, 16'hFFFF, 0));
        send_sample(pack_sample(127, 65535, 0, 16'hFFFF, 0));
        send_sample(pack_sample(128, 0, 0, 0, 0));                // zero equals zero: no hit
        send_sample(pack_sample(128, 1, 16, 0, 0));
        send_sample(pack_sample(128, 1, 15, 0, 0));               // just above
        send_sample(pack_sample(200, 0, 0, 0, 1));                // end of event on noise
        send_sample(pack_sample(50, 100, 0, 256, 1));             // seed closing its own event
        send_sample(pack_sample(10, 48, 0, 256, 0));              // on the hit threshold
        send_sample(pack_sample(10, 49, 0, 256, 0));
        send_sample(pack_sample(11, 81, 0, 256, 0));
        send_sample(pack_sample(12, 80, 0, 256, 1));              // on the seed threshold
        drain();

        run_phase(15);

        // Lower thresholds and mixed masks; output held while a long run fills the buffer
        write_reg(REG_HIT_FACTOR, 64'd16);
        write_reg(REG_SEED_FACTOR, 64'd40);
        write_reg(REG_MASK_0, {$urandom, $urandom});
        write_reg(REG_MASK_1, '1);
        write_reg(REG_MASK_2, 64'd0);
        write_reg(REG_MASK_3, {$urandom, $urandom});
        hold_req = 1'b1;
        run_event(20, 40, 100, 15, 1'b1);
        run_phase(10);

        // Zero factors, no idling on either side
        write_reg(REG_HIT_FACTOR, 64'd0);
        write_reg(REG_SEED_FACTOR, 64'd0);
        write_reg(REG_MASK_0, '1);
        write_reg(REG_MASK_1, 64'd0);
        steady = 1'b1;
        run_phase(25);
        steady = 1'b0;

        // Top factors, every channel masked but 64 to 127
        write_reg(REG_HIT_FACTOR, 64'd255);
        write_reg(REG_SEED_FACTOR, 64'd255);
        write_reg(REG_MASK_2, '1);
        write_reg(REG_MASK_3, '1);
        run_phase(10);

        // Seed factor under hit factor; isolated seeds wrap the cluster number
        write_reg(REG_HIT_FACTOR, 64'd200);
        write_reg(REG_SEED_FACTOR, 64'd30);
        write_reg(REG_MASK_0, 64'd0);
        for (int k = 0; k < 130; k++)
            send_sample(make_sample((2 * k) & 255, LVL_SEED, k == 129));
        drain();
        run_phase(5);

        // Back to reset thresholds with random masks
        write_reg(REG_HIT_FACTOR, {56'd0, HIT_FACTOR_RST});
        write_reg(REG_SEED_FACTOR, {56'd0, SEED_FACTOR_RST});
        write_reg(REG_MASK_1, {$urandom, $urandom});
        write_reg(REG_MASK_2, {$urandom, $urandom});
        run_phase(15);

        $display("Covered: %0d samples, %0d hit items, %0d clusters, %0d dropped, %0d split",
                 tracker.samples, tracker.hits_out, tracker.clusters_out,
                 tracker.dropped, tracker.full_splits);
        $display("         %0d golden gate, %0d bad channel, %0d number wraps, %0d writes",
                 tracker.golden, tracker.bad, tracker.wraps, tracker.reg_writes);
        if (tracker.errors == 0) begin
            $display("strip_seed_hit_clusterer verification clean");
        end else begin
            $display("%0d errors", tracker.errors);
            $display("strip_seed_hit_clusterer verification failed");
        end
        $finish;
    end

endmodule
